>>> sv/bed_pkg.sv
`default_nettype none

package bed_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_SKIP   = 2'd3
  } mode_t;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] LETTER_U  = 8'h75;
  localparam logic [4:0] HEX_NONE  = 5'd16;
  localparam logic [7:0] HEX_ALPHA = 8'd10;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    logic        aborted;
    logic        last_of_item;
  } result_t;

  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] count;
  } decode_t;

  function automatic logic is_simple_escape(input logic [7:0] c);
    return c == 8'h22 || c == 8'h2F || c == BACKSLASH || c == 8'h62 ||
           c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + HEX_ALPHA;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + HEX_ALPHA;
    end else begin
      return HEX_NONE;
    end
    return {1'b0, v[3:0]};
  endfunction

endpackage

`default_nettype wire

>>> sv/backslash_escape_decoder.sv
// an input byte is held in the input register, and its decoded results are registered in the output buffer
// throughput: one byte per cycle while out_stall is low; a byte that yields two results holds input until slot b drains
// the rate is set by the two-slot output buffer, which must have room before a byte decodes
// reset: synchronous active-high rst empties the input register and both output slots and returns to normal text mode
`default_nettype none

module backslash_escape_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      code_unit,
  output logic             is_end,
  output logic             aborted,
  output logic             last_of_item
);

  logic             r_full;
  logic [7:0]       r_char;
  logic             room;
  logic             fire;
  bed_pkg::decode_t dec;
  bed_pkg::result_t res;

  assign fire = r_full && room;

  bed_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_in  (char_in),
    .take     (fire),
    .full     (r_full),
    .char_r   (r_char)
  );

  bed_decoder u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .c    (r_char),
    .dec  (dec)
  );

  bed_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .dec       (dec),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign code_unit    = res.code_unit;
  assign is_end       = res.is_end;
  assign aborted      = res.aborted;
  assign last_of_item = res.last_of_item;

endmodule

`default_nettype wire

>>> sv/bed_in_reg.sv
`default_nettype none

module bed_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       take,
  output logic            full,
  output logic [7:0]      char_r
);

  logic load;

  assign in_stall = full && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_in;
    end
  end

endmodule

`default_nettype wire

>>> sv/bed_decoder.sv
`default_nettype none

module bed_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] c,
  output bed_pkg::decode_t dec
);

  bed_pkg::mode_t mode, mode_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [15:0] acc, acc_next;
  logic [4:0]  d;

  assign d = bed_pkg::hex_value(c);

  always_comb begin
    mode_next     = mode;
    hex_seen_next = hex_seen;
    acc_next      = acc;
    unique case (mode)
      bed_pkg::MODE_TEXT: begin
        mode_next = (c == bed_pkg::BACKSLASH) ? bed_pkg::MODE_ESCAPE : bed_pkg::MODE_TEXT;
      end
      bed_pkg::MODE_ESCAPE: begin
        if (c == bed_pkg::LETTER_U) begin
          mode_next     = bed_pkg::MODE_HEX;
          hex_seen_next = 2'd0;
          acc_next      = 16'd0;
        end else if (bed_pkg::is_simple_escape(c)) begin
          mode_next = bed_pkg::MODE_TEXT;
        end else begin
          mode_next = (c == bed_pkg::BACKSLASH) ? bed_pkg::MODE_ESCAPE : bed_pkg::MODE_TEXT;
        end
      end
      bed_pkg::MODE_HEX: begin
        if (d != bed_pkg::HEX_NONE) begin
          acc_next = {acc[11:0], d[3:0]};
          if (hex_seen == 2'd3) begin
            mode_next     = bed_pkg::MODE_TEXT;
            hex_seen_next = 2'd0;
          end else begin
            hex_seen_next = hex_seen + 2'd1;
          end
        end else if (c == 8'd0) begin
          mode_next     = bed_pkg::MODE_TEXT;
          hex_seen_next = 2'd0;
        end else begin
          mode_next     = bed_pkg::MODE_SKIP;
          hex_seen_next = 2'd0;
        end
      end
      bed_pkg::MODE_SKIP: begin
        if (c == 8'd0) begin
          mode_next = bed_pkg::MODE_TEXT;
        end
      end
      default: begin
        mode_next = bed_pkg::MODE_TEXT;
      end
    endcase
  end

  always_comb begin
    dec = '0;
    unique case (mode)
      bed_pkg::MODE_TEXT: begin
        if (c == 8'd0) begin
          dec.r0    = '{code_unit: 16'd0, is_end: 1'b1, aborted: 1'b0, last_of_item: 1'b1};
          dec.count = 2'd1;
        end else if (c != bed_pkg::BACKSLASH) begin
          dec.r0    = '{code_unit: {8'd0, c}, is_end: 1'b0, aborted: 1'b0, last_of_item: 1'b1};
          dec.count = 2'd1;
        end
      end
      bed_pkg::MODE_ESCAPE: begin
        if (c == bed_pkg::LETTER_U) begin
          dec.count = 2'd0;
        end else if (bed_pkg::is_simple_escape(c)) begin
          dec.r0    = '{code_unit: {8'd0, c}, is_end: 1'b0, aborted: 1'b0, last_of_item: 1'b1};
          dec.count = 2'd1;
        end else if (c == bed_pkg::BACKSLASH) begin
          dec.r0    = '{code_unit: {8'd0, bed_pkg::BACKSLASH}, is_end: 1'b0,
                        aborted: 1'b0, last_of_item: 1'b1};
          dec.count = 2'd1;
        end else begin
          dec.r0    = '{code_unit: {8'd0, bed_pkg::BACKSLASH}, is_end: 1'b0,
                        aborted: 1'b0, last_of_item: 1'b0};
          dec.r1    = '{code_unit: (c == 8'd0) ? 16'd0 : {8'd0, c}, is_end: (c == 8'd0),
                        aborted: 1'b0, last_of_item: 1'b1};
          dec.count = 2'd2;
        end
      end
      bed_pkg::MODE_HEX: begin
        if (d != bed_pkg::HEX_NONE) begin
          if (hex_seen == 2'd3) begin
            dec.r0    = '{code_unit: {acc[11:0], d[3:0]}, is_end: 1'b0, aborted: 1'b0,
                          last_of_item: 1'b1};
            dec.count = 2'd1;
          end
        end else if (c == 8'd0) begin
          dec.r0    = '{code_unit: 16'd0, is_end: 1'b1, aborted: 1'b1, last_of_item: 1'b1};
          dec.count = 2'd1;
        end
      end
      bed_pkg::MODE_SKIP: begin
        if (c == 8'd0) begin
          dec.r0    = '{code_unit: 16'd0, is_end: 1'b1, aborted: 1'b1, last_of_item: 1'b1};
          dec.count = 2'd1;
        end
      end
      default: begin
        dec = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= bed_pkg::MODE_TEXT;
      hex_seen <= 2'd0;
      acc      <= 16'd0;
    end else if (fire) begin
      mode     <= mode_next;
      hex_seen <= hex_seen_next;
      acc      <= acc_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_hex_count_idle: assert property (@(posedge clk) disable iff (rst)
    (mode != bed_pkg::MODE_HEX) |-> (hex_seen == 2'd0))
    else $error("hex digit count left over outside hex mode");
  a_pair_from_escape: assert property (@(posedge clk) disable iff (rst)
    (fire && dec.count == 2'd2) |-> (mode == bed_pkg::MODE_ESCAPE))
    else $error("two results outside escape mode");
  a_abort_on_end: assert property (@(posedge clk) disable iff (rst)
    (fire && dec.count != 2'd0 && dec.r0.aborted) |-> (dec.r0.is_end && dec.count == 2'd1))
    else $error("aborted flag on a non-end result");
`endif

endmodule

`default_nettype wire

>>> sv/bed_out_buf.sv
`default_nettype none

module bed_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bed_pkg::decode_t  dec,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bed_pkg::result_t       res
);

  logic             a_full, b_full;
  bed_pkg::result_t a, b;
  logic             a_leave;
  logic             push_any;

  assign a_leave   = a_full && !out_stall;
  assign room      = !b_full && (!a_full || !out_stall);
  assign push_any  = push && dec.count != 2'd0;
  assign out_valid = a_full;
  assign res       = a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_full <= 1'b0;
      b_full <= 1'b0;
    end else if (push_any) begin
      a_full <= 1'b1;
      b_full <= (dec.count == 2'd2);
    end else if (a_leave) begin
      a_full <= b_full;
      b_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_any) begin
      a <= dec.r0;
      b <= dec.r1;
    end else if (a_leave && b_full) begin
      a <= b;
    end
  end

`ifndef NO_ASSERTIONS
  a_b_behind_a: assert property (@(posedge clk) disable iff (rst)
    b_full |-> a_full)
    else $error("second slot full with first slot empty");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push_any |-> (!b_full && (!a_full || !out_stall)))
    else $error("push into a full buffer");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (a_full && out_stall) |=> a_full)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire
